// ----- rtl/sspi_pkg.sv -----
// Shared sizes and codes for the sound-speed profile interpolator.
package sspi_pkg;

   localparam int MAX_SLICES = 16;
   localparam int MAX_POINTS = 64;
   localparam int SLICE_W = $clog2(MAX_SLICES);
   localparam int POINT_W = $clog2(MAX_POINTS);
   localparam int SLICE_CNT_W = SLICE_W + 1;
   localparam int POINT_CNT_W = POINT_W + 1;
   localparam int CSR_W = 5;
   localparam int RANGE_W = 32;
   localparam int DEPTH_W = 32;
   localparam int SPEED_W = 28;
   localparam int GRAD_W = 32;

   typedef enum logic {
      CMD_LOAD  = 1'b0,
      CMD_QUERY = 1'b1
   } cmd_type;

   typedef enum logic {
      STATUS_OK         = 1'b0,
      STATUS_NO_PROFILE = 1'b1
   } status_type;

endpackage

// ----- rtl/sspi_if.sv -----
// Request and response channel interfaces of the sound-speed profile interpolator.
interface sspi_req_if;
   logic                                 valid;
   logic                                 ready;
   sspi_pkg::cmd_type                    command;
   logic [sspi_pkg::SLICE_W-1:0]         slice_index;
   logic [sspi_pkg::POINT_W-1:0]         point_index;
   logic signed [sspi_pkg::RANGE_W-1:0]  range_value;
   logic signed [sspi_pkg::DEPTH_W-1:0]  depth_value;
   logic [sspi_pkg::SPEED_W-1:0]         speed_value;

   modport source (output valid, command, slice_index, point_index, range_value,
                   depth_value, speed_value, input ready);
   modport sink (input valid, command, slice_index, point_index, range_value,
                 depth_value, speed_value, output ready);
endinterface

interface sspi_rsp_if;
   logic                                 valid;
   logic                                 ready;
   sspi_pkg::status_type                 status;
   logic [sspi_pkg::SPEED_W-1:0]         speed_out;
   logic signed [sspi_pkg::GRAD_W-1:0]   range_gradient;
   logic signed [sspi_pkg::GRAD_W-1:0]   depth_gradient;

   modport source (output valid, status, speed_out, range_gradient, depth_gradient,
                   input ready);
   modport sink (input valid, status, speed_out, range_gradient, depth_gradient,
                 output ready);
endinterface

// ----- rtl/sound_speed_profile_interp_core.sv -----
// Sound-speed profile interpolator: table memories, query sequencer and serial arithmetic.
// A load item writes one table point and gives no result. A query item runs through a
// sequencer over the slice range memory and the point memory, both read one entry per cycle
// with registered reads: it scans the range slices in use and fetches a bracketing pair,
// scans the points of each slice to find the depth segment, then runs a serial divider and
// a serial multiplier per step. A query clamped to a single slice evaluates that slice only,
// a depth that clamps to an end point skips that slice's divider and multiplier, and a query
// with no slices in use goes straight to the result.
// The result waits in an output register, so the next item is taken while it is pending.
module sound_speed_profile_interp_core (
   input  logic                          clock,
   input  logic                          reset,
   sspi_req_if.sink                      req_ch,
   sspi_rsp_if.source                    rsp_ch,
   input  logic                          csr_wr_en,
   input  logic [sspi_pkg::CSR_W-1:0]    csr_wr_data
);

   localparam int DIV_W = 57;
   localparam int DEN_W = 33;
   localparam int MUL_W = 34;
   localparam int PROD_W = 2 * MUL_W;
   localparam int CNT_W = 6;
   localparam int PT_W = sspi_pkg::DEPTH_W + sspi_pkg::SPEED_W;

   typedef enum logic [23:0] {
      ST_IDLE  = 24'h000001,
      ST_R_RD  = 24'h000002,
      ST_R_CMP = 24'h000004,
      ST_R_DEC = 24'h000008,
      ST_R_RK0 = 24'h000010,
      ST_R_RK1 = 24'h000020,
      ST_R_RK2 = 24'h000040,
      ST_S_N   = 24'h000080,
      ST_S_RD  = 24'h000100,
      ST_S_CMP = 24'h000200,
      ST_S_DEC = 24'h000400,
      ST_S_K0  = 24'h000800,
      ST_S_K1  = 24'h001000,
      ST_S_K2  = 24'h002000,
      ST_S_G   = 24'h004000,
      ST_S_C   = 24'h008000,
      ST_S_RET = 24'h010000,
      ST_P_S   = 24'h020000,
      ST_P_SP  = 24'h040000,
      ST_P_DG  = 24'h080000,
      ST_P_RG  = 24'h100000,
      ST_DIV   = 24'h200000,
      ST_MUL   = 24'h400000,
      ST_DONE  = 24'h800000
   } state_type;

   function automatic logic [MUL_W-1:0] mag34(input logic signed [MUL_W-1:0] x);
      logic signed [MUL_W-1:0] nx;
      nx = -x;
      return x[MUL_W-1] ? nx : x;
   endfunction

   // Signed quotient from magnitude and sign, saturated to the gradient width.
   function automatic logic signed [31:0] sat_q(input logic neg, input logic [DIV_W-1:0] q);
      logic [32:0] nq;
      nq = -{1'b0, q[31:0]};
      if (!neg) begin
         if (q > DIV_W'(32'h7FFF_FFFF)) return 32'sh7FFF_FFFF;
         return $signed(q[31:0]);
      end
      if (q > DIV_W'(33'h0_8000_0000)) return 32'sh8000_0000;
      return $signed(nq[31:0]);
   endfunction

   function automatic logic signed [31:0] sat_s(input logic signed [45:0] x);
      if (x > 46'sh0000_7FFF_FFFF) return 32'sh7FFF_FFFF;
      if (x < -46'sh0000_8000_0000) return 32'sh8000_0000;
      return x[31:0];
   endfunction

   function automatic logic [27:0] clamp_spd(input logic signed [53:0] x);
      if (x < 0) return '0;
      if (x > 54'sh0FF_FFFF) begin
         if (x > 54'sh0FFF_FFFF) return '1;
      end
      return x[27:0];
   endfunction

   // Memories and per-slice point counts.
   logic signed [31:0]       range_mem [sspi_pkg::MAX_SLICES];
   logic [PT_W-1:0]          point_mem [sspi_pkg::MAX_SLICES * sspi_pkg::MAX_POINTS];
   logic signed [31:0]       rng_rd_ff;
   logic [PT_W-1:0]          pt_rd_ff;
   logic [sspi_pkg::POINT_CNT_W-1:0] pps_ff [sspi_pkg::MAX_SLICES];

   state_type                state_ff, ret_ff;
   logic [sspi_pkg::CSR_W-1:0] csr_slices_ff;
   logic [sspi_pkg::SLICE_CNT_W-1:0] m_ff, m_now;
   logic signed [31:0]       r_ff, z_ff, rfst_ff, rlst_ff, r0_ff;
   logic signed [32:0]       dr_ff;
   logic [sspi_pkg::SLICE_W-1:0] j_ff, rk_ff, esl_ff;
   logic                     single_ff, pass_ff;
   logic [sspi_pkg::POINT_CNT_W-1:0] n_ff;
   logic [sspi_pkg::POINT_W-1:0] i_ff, kk_ff;
   logic signed [31:0]       dfst_ff, dlst_ff, d0_ff;
   logic [27:0]              cfst_ff, clst_ff, c0_ff, c_ff, c1_ff;
   logic signed [31:0]       g_ff, g1_ff;
   logic [24:0]              s_ff;
   logic [DIV_W-1:0]         num_ff;
   logic [DEN_W-1:0]         den_ff;
   logic [DEN_W-1:0]         rem_ff;
   logic                     neg_ff;
   logic [MUL_W-1:0]         mul_a_ff;
   logic [PROD_W-1:0]        prod_ff;
   logic [CNT_W-1:0]         cnt_ff;
   sspi_pkg::status_type     st_res_ff;
   logic [27:0]              spd_res_ff;
   logic signed [31:0]       rg_res_ff, dg_res_ff;
   logic                     rsp_valid_ff;
   sspi_pkg::status_type     rsp_status_ff;
   logic [27:0]              rsp_speed_ff;
   logic signed [31:0]       rsp_rg_ff, rsp_dg_ff;

   logic                     req_acc, load_acc;
   logic [sspi_pkg::SLICE_W-1:0] rng_addr;
   logic [sspi_pkg::POINT_W-1:0] pt_idx;
   logic signed [31:0]       pt_d;
   logic [27:0]              pt_c;
   logic [DEN_W:0]           rem_sh;
   logic                     fit;
   logic [MUL_W:0]           mul_sum;
   logic signed [32:0]       dr_w, dz_w, dist_w, zd_w;
   logic signed [28:0]       dc_w, dc12_w;
   logic signed [32:0]       dg12_w;
   logic signed [31:0]       gq_w;
   logic signed [53:0]       t16_w, t24_w, spd_sum_w;
   logic signed [45:0]       dg_sum_w;

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_acc = req_ch.valid && req_ch.ready;
   assign load_acc = req_acc && (req_ch.command == sspi_pkg::CMD_LOAD);
   assign m_now = (csr_slices_ff > sspi_pkg::CSR_W'(sspi_pkg::MAX_SLICES)) ?
                  sspi_pkg::SLICE_CNT_W'(sspi_pkg::MAX_SLICES) :
                  sspi_pkg::SLICE_CNT_W'(csr_slices_ff);

   assign rng_addr = (state_ff == ST_R_RK0) ? rk_ff :
                     (state_ff == ST_R_RK1) ? rk_ff + 1'b1 : j_ff;
   assign pt_idx = (state_ff == ST_S_K0) ? kk_ff :
                   (state_ff == ST_S_K1) ? kk_ff + 1'b1 : i_ff;
   assign pt_d = $signed(pt_rd_ff[PT_W-1:sspi_pkg::SPEED_W]);
   assign pt_c = pt_rd_ff[sspi_pkg::SPEED_W-1:0];

   assign rem_sh = {rem_ff, num_ff[DIV_W-1]};
   assign fit = rem_sh >= {1'b0, den_ff};
   assign mul_sum = {1'b0, prod_ff[PROD_W-1:MUL_W]} + (prod_ff[0] ? {1'b0, mul_a_ff} : '0);

   assign dr_w = 33'(rng_rd_ff) - 33'(r0_ff);
   assign dz_w = 33'(pt_d) - 33'(d0_ff);
   assign dist_w = 33'(r_ff) - 33'(r0_ff);
   assign zd_w = 33'(z_ff) - 33'(d0_ff);
   assign dc_w = $signed({1'b0, pt_c}) - $signed({1'b0, c0_ff});
   assign dc12_w = $signed({1'b0, c_ff}) - $signed({1'b0, c1_ff});
   assign dg12_w = 33'(g_ff) - 33'(g1_ff);
   assign gq_w = sat_q(neg_ff, num_ff);
   assign t16_w = $signed({2'b00, prod_ff[PROD_W-1:16]});
   assign t24_w = $signed({10'b0, prod_ff[PROD_W-1:24]});
   assign spd_sum_w = $signed({26'b0, c1_ff}) + (neg_ff ? -t24_w : t24_w);
   assign dg_sum_w = 46'(g1_ff) + (neg_ff ? -t24_w[45:0] : t24_w[45:0]);

   // Table memories with registered reads.
   always_ff @(posedge clock) begin
      if (load_acc) begin
         range_mem[req_ch.slice_index] <= req_ch.range_value;
         point_mem[{req_ch.slice_index, req_ch.point_index}] <=
            {req_ch.depth_value, req_ch.speed_value};
      end
      rng_rd_ff <= range_mem[rng_addr];
      pt_rd_ff <= point_mem[{esl_ff, pt_idx}];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ret_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         csr_slices_ff <= '0;
         for (int p = 0; p < sspi_pkg::MAX_SLICES; p++) begin
            pps_ff[p] <= '0;
         end
      end else begin
         if (csr_wr_en) begin
            csr_slices_ff <= csr_wr_data;
         end
         // The finishing state refills the output register itself.
         if (rsp_ch.ready && (state_ff != ST_DONE)) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (load_acc) begin
                  pps_ff[req_ch.slice_index] <= {1'b0, req_ch.point_index} + 1'b1;
               end else if (req_acc) begin
                  r_ff <= req_ch.range_value;
                  z_ff <= req_ch.depth_value;
                  m_ff <= m_now;
                  j_ff <= '0;
                  rk_ff <= '0;
                  pass_ff <= 1'b0;
                  if (m_now == '0) begin
                     st_res_ff <= sspi_pkg::STATUS_NO_PROFILE;
                     spd_res_ff <= '0;
                     rg_res_ff <= '0;
                     dg_res_ff <= '0;
                     state_ff <= ST_DONE;
                  end else begin
                     state_ff <= ST_R_RD;
                  end
               end
            end
            ST_R_RD: begin
               state_ff <= ST_R_CMP;
            end
            ST_R_CMP: begin
               if (j_ff == '0) begin
                  rfst_ff <= rng_rd_ff;
               end
               if (({1'b0, j_ff} + 1'b1 < m_ff) && (rng_rd_ff <= r_ff)) begin
                  rk_ff <= j_ff;
               end
               if ({1'b0, j_ff} + 1'b1 == m_ff) begin
                  rlst_ff <= rng_rd_ff;
                  state_ff <= ST_R_DEC;
               end else begin
                  j_ff <= j_ff + 1'b1;
                  state_ff <= ST_R_RD;
               end
            end
            ST_R_DEC: begin
               if ((m_ff == sspi_pkg::SLICE_CNT_W'(1)) || (r_ff <= rfst_ff)) begin
                  esl_ff <= '0;
                  single_ff <= 1'b1;
                  state_ff <= ST_S_N;
               end else if (r_ff >= rlst_ff) begin
                  esl_ff <= sspi_pkg::SLICE_W'(m_ff - 1'b1);
                  single_ff <= 1'b1;
                  state_ff <= ST_S_N;
               end else begin
                  state_ff <= ST_R_RK0;
               end
            end
            ST_R_RK0: begin
               state_ff <= ST_R_RK1;
            end
            ST_R_RK1: begin
               r0_ff <= rng_rd_ff;
               state_ff <= ST_R_RK2;
            end
            ST_R_RK2: begin
               dr_ff <= dr_w;
               esl_ff <= rk_ff;
               single_ff <= (dr_w <= 0);
               state_ff <= ST_S_N;
            end
            // Evaluation of one slice at the query depth.
            ST_S_N: begin
               n_ff <= pps_ff[esl_ff];
               i_ff <= '0;
               kk_ff <= '0;
               g_ff <= '0;
               if (pps_ff[esl_ff] == '0) begin
                  c_ff <= '0;
                  state_ff <= ST_S_RET;
               end else begin
                  state_ff <= ST_S_RD;
               end
            end
            ST_S_RD: begin
               state_ff <= ST_S_CMP;
            end
            ST_S_CMP: begin
               if (i_ff == '0) begin
                  dfst_ff <= pt_d;
                  cfst_ff <= pt_c;
               end
               if (({1'b0, i_ff} + 1'b1 < n_ff) && (pt_d <= z_ff)) begin
                  kk_ff <= i_ff;
               end
               if ({1'b0, i_ff} + 1'b1 == n_ff) begin
                  dlst_ff <= pt_d;
                  clst_ff <= pt_c;
                  state_ff <= ST_S_DEC;
               end else begin
                  i_ff <= i_ff + 1'b1;
                  state_ff <= ST_S_RD;
               end
            end
            ST_S_DEC: begin
               if ((n_ff == sspi_pkg::POINT_CNT_W'(1)) || (z_ff <= dfst_ff)) begin
                  c_ff <= cfst_ff;
                  state_ff <= ST_S_RET;
               end else if (z_ff >= dlst_ff) begin
                  c_ff <= clst_ff;
                  state_ff <= ST_S_RET;
               end else begin
                  state_ff <= ST_S_K0;
               end
            end
            ST_S_K0: begin
               state_ff <= ST_S_K1;
            end
            ST_S_K1: begin
               d0_ff <= pt_d;
               c0_ff <= pt_c;
               state_ff <= ST_S_K2;
            end
            ST_S_K2: begin
               if (dz_w <= 0) begin
                  c_ff <= c0_ff;
                  state_ff <= ST_S_RET;
               end else begin
                  num_ff <= DIV_W'({mag34(MUL_W'(dc_w)), 16'b0});
                  den_ff <= dz_w;
                  neg_ff <= dc_w[28];
                  rem_ff <= '0;
                  cnt_ff <= '0;
                  ret_ff <= ST_S_G;
                  state_ff <= ST_DIV;
               end
            end
            ST_S_G: begin
               g_ff <= gq_w;
               mul_a_ff <= MUL_W'(zd_w);
               prod_ff <= {{MUL_W{1'b0}}, mag34(MUL_W'(gq_w))};
               neg_ff <= gq_w[31];
               cnt_ff <= '0;
               ret_ff <= ST_S_C;
               state_ff <= ST_MUL;
            end
            ST_S_C: begin
               c_ff <= clamp_spd($signed({26'b0, c0_ff}) + (neg_ff ? -t16_w : t16_w));
               state_ff <= ST_S_RET;
            end
            ST_S_RET: begin
               if (!pass_ff) begin
                  c1_ff <= c_ff;
                  g1_ff <= g_ff;
                  if (single_ff) begin
                     st_res_ff <= sspi_pkg::STATUS_OK;
                     spd_res_ff <= c_ff;
                     dg_res_ff <= g_ff;
                     rg_res_ff <= '0;
                     state_ff <= ST_DONE;
                  end else begin
                     pass_ff <= 1'b1;
                     esl_ff <= rk_ff + 1'b1;
                     state_ff <= ST_S_N;
                  end
               end else begin
                  // Range fraction of the query between the two slices.
                  num_ff <= {dist_w[31:0], 25'b0} >> 1;
                  den_ff <= dr_ff;
                  neg_ff <= 1'b0;
                  rem_ff <= '0;
                  cnt_ff <= '0;
                  ret_ff <= ST_P_S;
                  state_ff <= ST_DIV;
               end
            end
            ST_P_S: begin
               s_ff <= (num_ff > DIV_W'(25'h100_0000)) ? 25'h100_0000 : num_ff[24:0];
               mul_a_ff <= mag34(MUL_W'(dc12_w));
               prod_ff <= {{MUL_W{1'b0}},
                           ((num_ff > DIV_W'(25'h100_0000)) ? MUL_W'(25'h100_0000) :
                                                              MUL_W'(num_ff[24:0]))};
               neg_ff <= dc12_w[28];
               cnt_ff <= '0;
               ret_ff <= ST_P_SP;
               state_ff <= ST_MUL;
            end
            ST_P_SP: begin
               spd_res_ff <= clamp_spd(spd_sum_w);
               mul_a_ff <= mag34(MUL_W'(dg12_w));
               prod_ff <= {{MUL_W{1'b0}}, MUL_W'(s_ff)};
               neg_ff <= dg12_w[32];
               cnt_ff <= '0;
               ret_ff <= ST_P_DG;
               state_ff <= ST_MUL;
            end
            ST_P_DG: begin
               dg_res_ff <= sat_s(dg_sum_w);
               num_ff <= DIV_W'({mag34(MUL_W'(dc12_w)), 16'b0});
               den_ff <= dr_ff;
               neg_ff <= dc12_w[28];
               rem_ff <= '0;
               cnt_ff <= '0;
               ret_ff <= ST_P_RG;
               state_ff <= ST_DIV;
            end
            ST_P_RG: begin
               rg_res_ff <= gq_w;
               st_res_ff <= sspi_pkg::STATUS_OK;
               state_ff <= ST_DONE;
            end
            // Restoring divider, one quotient bit per cycle.
            ST_DIV: begin
               rem_ff <= fit ? DEN_W'(rem_sh - {1'b0, den_ff}) : DEN_W'(rem_sh);
               num_ff <= {num_ff[DIV_W-2:0], fit};
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == CNT_W'(DIV_W - 1)) begin
                  state_ff <= ret_ff;
               end
            end
            // Shift-and-add multiplier, one multiplier bit per cycle.
            ST_MUL: begin
               prod_ff <= {mul_sum, prod_ff[MUL_W-1:1]};
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == CNT_W'(MUL_W - 1)) begin
                  state_ff <= ret_ff;
               end
            end
            ST_DONE: begin
               if (!rsp_valid_ff || rsp_ch.ready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_status_ff <= st_res_ff;
                  rsp_speed_ff <= spd_res_ff;
                  rsp_rg_ff <= rg_res_ff;
                  rsp_dg_ff <= dg_res_ff;
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.status = rsp_status_ff;
   assign rsp_ch.speed_out = rsp_speed_ff;
   assign rsp_ch.range_gradient = rsp_rg_ff;
   assign rsp_ch.depth_gradient = rsp_dg_ff;

   a_point_scan_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_S_CMP) |-> ({1'b0, i_ff} < n_ff))
      else $error("point scan ran past the slice's point count");

   a_slice_scan_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_R_CMP) |-> ({1'b0, j_ff} < m_ff))
      else $error("slice scan ran past the slices in use");

   a_no_profile_fast: assert property (@(posedge clock) disable iff (reset)
      (req_acc && req_ch.command == sspi_pkg::CMD_QUERY && m_now == '0)
      |=> (state_ff == ST_DONE))
      else $error("query without profile did not go straight to the result");

   a_done_delivers: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && (!rsp_valid_ff || rsp_ch.ready)) |=> rsp_valid_ff)
      else $error("finished query did not present its item");

endmodule
